// File: sv/lcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and constants for the Lehmer code to permutation decoder.
// ----------------------------------------------------------------------------
package lcp_pkg;

  localparam int MAX_LEN  = 16;
  localparam int ELEM_W   = $clog2(MAX_LEN);
  localparam int LEN_W    = ELEM_W + 1;
  localparam int LETTER_W = 7;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCW      = QAW + 1;

  localparam logic [LETTER_W-1:0] LETTER_BASE = LETTER_W'(97);
  localparam logic [LEN_W-1:0]    MIN_LEN     = LEN_W'(2);

  typedef logic [MAX_LEN-1:0][ELEM_W-1:0] list_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic [ELEM_W-1:0]   position;
    logic                last;
    logic                bad_digit;
  } result_t;

  typedef struct packed {
    result_t           first;
    result_t           second;
    logic              two;
    logic              restart;
    list_t             list_next;
    logic [ELEM_W-1:0] pos_next;
  } step_t;

  // Full list of unused elements: entry i holds i
  function automatic list_t identity_list();
    list_t l;
    for (int i = 0; i < MAX_LEN; i++) begin
      l[i] = ELEM_W'(i);
    end
    return l;
  endfunction

endpackage

// File: sv/lcp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_step
// One decode step: select the digit-th unused element, compact the list and
// form one or two results.
// ----------------------------------------------------------------------------
module lcp_step (
  input  lcp_pkg::list_t                    list,
  input  logic [lcp_pkg::ELEM_W-1:0]        next_position,
  input  logic [lcp_pkg::LEN_W-1:0]         len,
  input  logic [lcp_pkg::ELEM_W-1:0]        digit,
  output lcp_pkg::step_t                    step
);

  logic                         stale;
  logic [lcp_pkg::ELEM_W-1:0]   pos;
  lcp_pkg::list_t               cur;
  lcp_pkg::list_t               shifted;
  logic [lcp_pkg::LEN_W-1:0]    rem;
  logic [lcp_pkg::LEN_W-1:0]    pos_inc;
  logic                         bad;
  logic                         done;
  logic [lcp_pkg::ELEM_W-1:0]   chosen;

  // Recover from an out-of-range position as a fresh start
  always_comb begin
    stale = {1'b0, next_position} >= (len - lcp_pkg::LEN_W'(1));
    pos   = stale ? '0 : next_position;
    cur   = stale ? lcp_pkg::identity_list() : list;
  end

  // Select the element and close the gap it leaves
  always_comb begin
    rem     = len - {1'b0, pos};
    bad     = {1'b0, digit} >= rem;
    chosen  = cur[digit];
    pos_inc = {1'b0, pos} + lcp_pkg::LEN_W'(1);
    done    = pos_inc == (len - lcp_pkg::LEN_W'(1));
    for (int i = 0; i < lcp_pkg::MAX_LEN - 1; i++) begin
      shifted[i] = (i < int'(digit)) ? cur[i] : cur[i+1];
    end
    shifted[lcp_pkg::MAX_LEN-1] = cur[lcp_pkg::MAX_LEN-1];
  end

  // Build results and the state that follows
  always_comb begin
    step.first.letter     = bad ? '0
                                : lcp_pkg::LETTER_BASE + lcp_pkg::LETTER_W'(chosen);
    step.first.position   = pos;
    step.first.last       = bad;
    step.first.bad_digit  = bad;
    step.second.letter    = lcp_pkg::LETTER_BASE + lcp_pkg::LETTER_W'(shifted[0]);
    step.second.position  = pos_inc[lcp_pkg::ELEM_W-1:0];
    step.second.last      = 1'b1;
    step.second.bad_digit = 1'b0;
    step.two              = !bad && done;
    step.restart          = bad || done;
    step.list_next        = step.restart ? lcp_pkg::identity_list() : shifted;
    step.pos_next         = step.restart ? '0 : pos_inc[lcp_pkg::ELEM_W-1:0];
  end

endmodule

// File: sv/lcp_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_out_queue
// Small result queue: takes one or two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module lcp_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  logic             push1,
  input  lcp_pkg::result_t d0,
  input  lcp_pkg::result_t d1,
  input  logic             pop,
  output logic             not_empty,
  output logic             has_room,
  output lcp_pkg::result_t q
);

  lcp_pkg::result_t           mem [lcp_pkg::QDEPTH];
  logic [lcp_pkg::QAW-1:0]    wr_ptr;
  logic [lcp_pkg::QAW-1:0]    rd_ptr;
  logic [lcp_pkg::QCW-1:0]    count;
  logic [lcp_pkg::QCW-1:0]    count_next;
  logic [lcp_pkg::QAW-1:0]    wr_ptr_next;

  // Track fill level
  always_comb begin
    count_next = count + lcp_pkg::QCW'(push0) + lcp_pkg::QCW'(push1)
                 - lcp_pkg::QCW'(pop);
    wr_ptr_next = wr_ptr + lcp_pkg::QAW'(push0) + lcp_pkg::QAW'(push1);
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + lcp_pkg::QAW'(1);
      end
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= d0;
    end
    if (push1) begin
      mem[wr_ptr + lcp_pkg::QAW'(1)] <= d1;
    end
  end

  assign q         = mem[rd_ptr];
  assign not_empty = count != '0;
  assign has_room  = count <= lcp_pkg::QCW'(lcp_pkg::QDEPTH - 2);

endmodule

// File: sv/lehmer_code_to_permutation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lehmer_code_to_permutation_unit
// Decodes Lehmer digits into permutation letters, one digit per cycle while in_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, digit) takes one Lehmer digit per
//   request. Output channel (out_valid/out_ready) carries letter, position,
//   last and bad_digit. Each digit yields one result; the digit that ends a
//   permutation yields a second result holding the final element, marked
//   last. A digit not below the remaining count yields one error result
//   (bad_digit and last set) and restarts the permutation.
//   Results enter a registered queue when their digit is accepted.
//   Throughput: one digit per cycle while in_ready is high; a closing digit
//   yields two results, which leave one at a time by the queue's single
//   output port. The queue is four entries deep and in_ready drops when
//   fewer than two are free, so a stalled receiver backs up into the input.
//   Reset sets perm_length to 16 and starts a fresh permutation. A write on
//   cfg_we sets perm_length (clamped to 2..16) and also restarts.
// ----------------------------------------------------------------------------
module lehmer_code_to_permutation_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lcp_pkg::LEN_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcp_pkg::ELEM_W-1:0]    digit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcp_pkg::LETTER_W-1:0]  letter,
  output logic [lcp_pkg::ELEM_W-1:0]    position,
  output logic                          last,
  output logic                          bad_digit
);

  logic [lcp_pkg::LEN_W-1:0]  perm_length;
  logic [lcp_pkg::LEN_W-1:0]  len;
  lcp_pkg::list_t             list;
  logic [lcp_pkg::ELEM_W-1:0] next_position;
  lcp_pkg::step_t             step;
  lcp_pkg::result_t           q;
  logic                       accept;
  logic                       has_room;

  // Clamp the configured length
  always_comb begin
    priority if (perm_length < lcp_pkg::MIN_LEN) begin
      len = lcp_pkg::MIN_LEN;
    end else if (perm_length > lcp_pkg::LEN_W'(lcp_pkg::MAX_LEN)) begin
      len = lcp_pkg::LEN_W'(lcp_pkg::MAX_LEN);
    end else begin
      len = perm_length;
    end
  end

  assign in_ready = has_room;
  assign accept   = in_valid && in_ready;

  lcp_step u_step (
    .list          (list),
    .next_position (next_position),
    .len           (len),
    .digit         (digit),
    .step          (step)
  );

  // Hold the unused-element list; restart on config or end of permutation
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length   <= lcp_pkg::LEN_W'(lcp_pkg::MAX_LEN);
      list          <= lcp_pkg::identity_list();
      next_position <= '0;
    end else if (cfg_we) begin
      perm_length   <= cfg_wdata;
      list          <= lcp_pkg::identity_list();
      next_position <= '0;
    end else if (accept) begin
      list          <= step.list_next;
      next_position <= step.pos_next;
    end
  end

  lcp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (accept),
    .push1     (accept && step.two),
    .d0        (step.first),
    .d1        (step.second),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .has_room  (has_room),
    .q         (q)
  );

  assign letter    = q.letter;
  assign position  = q.position;
  assign last      = q.last;
  assign bad_digit = q.bad_digit;

endmodule

// File: test/lehmer_code_to_permutation_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lehmer_code_to_permutation_unit_tb
// Self-checking bench for the Lehmer code decoder. A driver streams digits in
// random bursts, a receiver stalls on its own pattern, and a scoreboard
// decodes every accepted digit into the letters the unit must return, in
// order. Runs a directed set first, then random permutations across several
// lengths, including clamped ones.
// ----------------------------------------------------------------------------
module lehmer_code_to_permutation_unit_tb;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 117;
  localparam int NUM_PHASES  = 9;

  typedef struct {
    logic [lcp_pkg::ELEM_W-1:0] value;
    bit                         drain;
  } digit_req_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_ONE_IN_FOUR,
    READY_COIN
  } stall_mode_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [lcp_pkg::LEN_W-1:0]    cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [lcp_pkg::ELEM_W-1:0]   digit = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [lcp_pkg::LETTER_W-1:0] letter;
  logic [lcp_pkg::ELEM_W-1:0]   position;
  logic                         last;
  logic                         bad_digit;

  // Decoder state mirrored by the scoreboard
  logic [lcp_pkg::ELEM_W-1:0]   unused_elems [lcp_pkg::MAX_LEN];
  logic [lcp_pkg::ELEM_W-1:0]   next_pos;
  logic [lcp_pkg::LEN_W-1:0]    length_reg;

  lcp_pkg::result_t pending_results [$];
  digit_req_t       digit_requests [$];
  digit_req_t       cur_req;
  int               burst_left;
  int               gap_left;
  stall_mode_t      stall_mode;
  int               mode_left;
  int               cycle_count = 0;
  int               n_errors = 0;

  lehmer_code_to_permutation_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .digit     (digit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .letter    (letter),
    .position  (position),
    .last      (last),
    .bad_digit (bad_digit)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int effective_length(input logic [lcp_pkg::LEN_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > lcp_pkg::MAX_LEN) return lcp_pkg::MAX_LEN;
    return int'(raw);
  endfunction

  // Refill the unused list and start a new permutation
  function automatic void restart_perm();
    for (int i = 0; i < lcp_pkg::MAX_LEN; i++) begin
      unused_elems[i] = lcp_pkg::ELEM_W'(i);
    end
    next_pos = '0;
  endfunction

  // Pick the selected element, compact the list, queue one or two results
  function automatic void decode_digit(input logic [lcp_pkg::ELEM_W-1:0] d);
    int               len;
    int               pos;
    int               rem;
    lcp_pkg::result_t r;
    len = effective_length(length_reg);
    pos = int'(next_pos);
    if (pos >= len - 1) begin
      restart_perm();
      pos = 0;
    end
    rem = len - pos;
    if (int'(d) >= rem) begin
      r = '{letter: '0, position: lcp_pkg::ELEM_W'(pos), last: 1'b1, bad_digit: 1'b1};
      pending_results.push_back(r);
      restart_perm();
      return;
    end
    r = '{letter: lcp_pkg::LETTER_BASE + lcp_pkg::LETTER_W'(unused_elems[d]),
          position: lcp_pkg::ELEM_W'(pos), last: 1'b0, bad_digit: 1'b0};
    pending_results.push_back(r);
    for (int i = int'(d); i + 1 < rem; i++) begin
      unused_elems[i] = unused_elems[i + 1];
    end
    pos++;
    next_pos = lcp_pkg::ELEM_W'(pos);
    if (pos == len - 1) begin
      r = '{letter: lcp_pkg::LETTER_BASE + lcp_pkg::LETTER_W'(unused_elems[0]),
            position: lcp_pkg::ELEM_W'(pos), last: 1'b1, bad_digit: 1'b0};
      pending_results.push_back(r);
      restart_perm();
    end
  endfunction

  function automatic void check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      n_errors++;
    end
  endfunction

  // Scoreboard: check results first, then decode newly accepted digits
  always @(posedge clk) begin
    lcp_pkg::result_t exp_r;
    if (rst) begin
      length_reg <= lcp_pkg::LEN_W'(lcp_pkg::MAX_LEN);
      restart_perm();
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        length_reg <= cfg_wdata;
        restart_perm();
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: letter %0d position %0d", letter, position);
          n_errors++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("letter", int'(exp_r.letter), int'(letter));
          check_field("position", int'(exp_r.position), int'(position));
          check_field("last", int'(exp_r.last), int'(last));
          check_field("bad_digit", int'(exp_r.bad_digit), int'(bad_digit));
        end
      end
      if (in_valid && in_ready) begin
        decode_digit(digit);
      end
    end
  end

  // Driver: send requests in bursts, hold a drain request until all results are back
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      gap_left   <= 0;
      burst_left <= $urandom_range(1, 24);
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (digit_requests.size() != 0 &&
                   !(digit_requests[0].drain && (in_valid || pending_results.size() != 0))) begin
        cur_req = digit_requests.pop_front();
        in_valid <= 1'b1;
        digit    <= cur_req.value;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: switch to a randomly chosen stall pattern whenever the current one runs out
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_mode <= READY_ALWAYS;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        READY_ALWAYS: begin
          out_ready <= 1'b1;
        end
        READY_MOSTLY: begin
          out_ready <= ($urandom_range(0, 9) < 7);
        end
        READY_ONE_IN_FOUR: begin
          out_ready <= (cycle_count % 4 == 0);
        end
        default: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
      endcase
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_digit(input int d, input bit drain);
    digit_req_t req;
    req.value = lcp_pkg::ELEM_W'(d);
    req.drain = drain;
    digit_requests.push_back(req);
  endtask

  // Block until every request is sent and every result has come back
  task automatic wait_idle();
    while (digit_requests.size() != 0 || in_valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input int raw);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lcp_pkg::LEN_W'(raw);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed permutations, with bad digits and plain noise mixed in
  task automatic queue_random_perms(input int raw, input int n_items);
    int len;
    int pos;
    int rem;
    int d;
    int r;
    int drain_at;
    len = effective_length(lcp_pkg::LEN_W'(raw));
    pos = 0;
    drain_at = $urandom_range(0, n_items - 1);
    for (int i = 0; i < n_items; i++) begin
      rem = len - pos;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        d = $urandom_range(0, rem - 1);
      end else if (r < 88) begin
        d = (r < 84) ? 0 : rem - 1;
      end else if (r < 94 && rem < lcp_pkg::MAX_LEN) begin
        d = $urandom_range(rem, lcp_pkg::MAX_LEN - 1);
      end else begin
        d = $urandom_range(0, lcp_pkg::MAX_LEN - 1);
      end
      queue_digit(d, i == drain_at);
      if (d >= rem) begin
        pos = 0;
      end else begin
        pos++;
        if (pos == len - 1) pos = 0;
      end
    end
  endtask

  initial begin
    int raw;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset length: top element, bad digit mid-permutation, then a partial one
    queue_digit(15, 0);
    queue_digit(0, 0);
    queue_digit(14, 0);
    queue_digit(0, 0);
    queue_digit(13, 0);
    wait_idle();

    // Shortest length; the write also abandons the partial permutation
    write_length(2);
    queue_digit(1, 0);
    queue_digit(0, 0);
    queue_digit(2, 0);
    queue_digit(15, 1);
    wait_idle();

    // Lengths below the minimum clamp up
    write_length(0);
    queue_digit(1, 0);
    queue_digit(0, 0);
    wait_idle();

    // Lengths above the maximum clamp down
    write_length(31);
    queue_digit(15, 0);
    queue_digit(15, 0);
    wait_idle();

    write_length(3);
    queue_digit(2, 0);
    queue_digit(1, 0);
    wait_idle();

    write_length(17);
    queue_digit(0, 0);
    wait_idle();

    write_length(1);
    queue_digit(0, 0);
    queue_digit(1, 0);
    wait_idle();

    // Random phases over fixed lengths, then random lengths
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: raw = 16;
        1: raw = 2;
        2: raw = 31;
        3: raw = 0;
        4: raw = 9;
        5: raw = 1;
        6: raw = 17;
        default: raw = $urandom_range(0, 31);
      endcase
      write_length(raw);
      queue_random_perms(raw, PHASE_ITEMS);
      wait_idle();
    end

    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: lehmer_code_to_permutation_unit.f
sv/lcp_pkg.sv
sv/lcp_step.sv
sv/lcp_out_queue.sv
sv/lehmer_code_to_permutation_unit.sv
test/lehmer_code_to_permutation_unit_tb.sv
